[hw/rtl/sttok_pkg.sv]
// Package for the source text tokeniser: lexer mode and escape codes, result word type,
// character class and decode helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sttok_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_CHAR    = 3'd3,
        MODE_NUMBER  = 3'd4,
        MODE_IDENT   = 3'd5,
        MODE_OPER    = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_SLASH = 2'd1,
        ESC_HEX   = 2'd2
    } esc_t;

    localparam logic [1:0] ITEM_TEXT  = 2'd0;
    localparam logic [1:0] ITEM_END   = 2'd1;
    localparam logic [1:0] ITEM_ERROR = 2'd2;

    localparam logic [2:0] TOK_NUMBER = 3'd0;
    localparam logic [2:0] TOK_IDENT  = 3'd1;
    localparam logic [2:0] TOK_OPER   = 3'd2;
    localparam logic [2:0] TOK_STRING = 3'd3;
    localparam logic [2:0] TOK_CHAR   = 3'd4;
    localparam logic [2:0] TOK_OTHER  = 3'd5;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_BAD_HEX = 2'd1;
    localparam logic [1:0] FAULT_OPEN    = 2'd2;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  text;
        logic [2:0]  tkind;
        logic [15:0] row;
        logic [15:0] col;
        logic [1:0]  fault;
        logic        last;
    } res_t;

    function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] text,
                                    input logic [2:0] tkind, input logic [15:0] row,
                                    input logic [15:0] col, input logic [1:0] fault);
        res_t r;
        r.kind  = kind;
        r.text  = text;
        r.tkind = tkind;
        r.row   = row;
        r.col   = col;
        r.fault = fault;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [2:0] mode_kind(input mode_t m);
        logic [2:0] k;
        unique case (m)
            MODE_NUMBER: k = TOK_NUMBER;
            MODE_IDENT:  k = TOK_IDENT;
            MODE_OPER:   k = TOK_OPER;
            MODE_CHAR:   k = TOK_CHAR;
            default:     k = TOK_STRING;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
               (c == 8'h25) || (c == 8'h26) || (c == 8'h7C) || (c == 8'h5E) ||
               (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h3F);
    endfunction

    // {valid, digit}
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] h;
        if (c >= 8'h30 && c <= 8'h39) begin
            h = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h = {1'b1, c[3:0] + 4'd9};
        end else begin
            h = 5'd0;
        end
        return h;
    endfunction

    // simple escapes; anything else stands for itself
    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] v;
        unique case (c)
            8'h61:   v = 8'h07;
            8'h62:   v = 8'h08;
            8'h65:   v = 8'h1B;
            8'h66:   v = 8'h0C;
            8'h6E:   v = 8'h0A;
            8'h72:   v = 8'h0D;
            8'h74:   v = 8'h09;
            8'h76:   v = 8'h0B;
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/source_text_tokenizer_unit.sv]
// Source text tokeniser top level: lexer state, single-pass byte decode and a four-word
// result queue feeding the master stream. Depends on sttok_pkg.
//
//  channel  | dir | tdata                  | tuser     | tlast
//  s_axis   | in  | char_code              | -         | end_of_input
//  m_axis   | out | text, kind, row, col,  | item_kind | last_of_run
//           |     | fault                  |           |
//
// Each accepted word is decoded in the cycle it is taken; its 0..3 result words are
// registered into the queue behind any words already waiting there.
// Throughput is one input word per cycle while each byte yields at most one result and
// m_axis_tready stays high; a byte yielding several results sends them one by one, and
// s_axis_tready drops while more than one result word waits in the queue.
// Reset (aresetn low, synchronous) empties the queue and returns the lexer to row 1, col 0.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer_unit
    import sttok_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] text_byte, [10:8] token_kind,
                                             // [26:11] start_row, [42:27] start_column,
                                             // [44:43] fault_code, [47:45] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] item_kind
    output logic             m_axis_tlast    // last_of_run
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    mode_t                    mode_reg, mode_next;
    esc_t                     esc_reg, esc_next;
    logic [2:0]               digits_reg, digits_next;
    logic [15:0]              hex_reg, hex_next;
    logic [POSITION_BITS-1:0] row_reg, row_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] trow_reg, trow_next;
    logic [POSITION_BITS-1:0] tcol_reg, tcol_next;

    res_t       q_reg [4];
    res_t       q_next [4];
    logic [2:0] cnt_reg, cnt_next;

    logic [7:0]               c;
    logic [POSITION_BITS-1:0] col_inc;
    logic [15:0]              row_o, col_o, coli_o, trow_o, tcol_o;
    logic [4:0]               hx;
    logic [15:0]              hex_acc;
    logic [2:0]               digits_dec;

    // normal-mode handling of the current byte
    mode_t      nb_mode;
    logic       nb_mark;
    logic [1:0] nb_n;
    res_t       nb_r0, nb_r1;

    res_t       res [3];
    logic [1:0] n;
    logic       push, pop;
    logic [2:0] base;
    logic [2:0] off;

    assign c       = s_axis_tdata;
    assign col_inc = (col_reg != POS_MAX) ? col_reg + 1'b1 : col_reg;
    assign row_o   = sat16(32'(row_reg));
    assign col_o   = sat16(32'(col_reg));
    assign coli_o  = sat16(32'(col_inc));
    assign trow_o  = sat16(32'(trow_reg));
    assign tcol_o  = sat16(32'(tcol_reg));
    assign hx      = hex_of(c);
    assign hex_acc = {hex_reg[11:0], hx[3:0]};
    assign digits_dec = digits_reg - 3'd1;

    always_comb begin
        nb_mode = MODE_NORMAL;
        nb_mark = 1'b0;
        nb_n    = 2'd0;
        nb_r0   = '0;
        nb_r1   = '0;
        priority if (c == CH_HASH) begin
            nb_mode = MODE_COMMENT;
        end else if (c == CH_DQUOTE) begin
            nb_mark = 1'b1;
            nb_mode = MODE_STRING;
        end else if (c == CH_SQUOTE) begin
            nb_mark = 1'b1;
            nb_mode = MODE_CHAR;
        end else if (c <= CH_SPACE) begin
            nb_mode = MODE_NORMAL;
        end else if (is_digit(c)) begin
            nb_mark = 1'b1;
            nb_mode = MODE_NUMBER;
            nb_n    = 2'd1;
            nb_r0   = mk_res(ITEM_TEXT, c, TOK_NUMBER, row_o, coli_o, FAULT_NONE);
        end else if (is_alpha(c) || c == CH_UNDER) begin
            nb_mark = 1'b1;
            nb_mode = MODE_IDENT;
            nb_n    = 2'd1;
            nb_r0   = mk_res(ITEM_TEXT, c, TOK_IDENT, row_o, coli_o, FAULT_NONE);
        end else if (is_op(c)) begin
            nb_mark = 1'b1;
            nb_mode = MODE_OPER;
            nb_n    = 2'd1;
            nb_r0   = mk_res(ITEM_TEXT, c, TOK_OPER, row_o, coli_o, FAULT_NONE);
        end else begin
            nb_mark = 1'b1;
            nb_n    = 2'd2;
            nb_r0   = mk_res(ITEM_TEXT, c, TOK_OTHER, row_o, coli_o, FAULT_NONE);
            nb_r1   = mk_res(ITEM_END, 8'd0, TOK_OTHER, row_o, coli_o, FAULT_NONE);
        end
    end

    always_comb begin
        logic more;
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        digits_next = digits_reg;
        hex_next    = hex_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        trow_next   = trow_reg;
        tcol_next   = tcol_reg;
        n           = 2'd0;
        res[0]      = '0;
        res[1]      = '0;
        res[2]      = '0;
        more        = 1'b0;

        if (s_axis_tlast) begin
            unique case (mode_reg)
                MODE_COMMENT, MODE_STRING, MODE_CHAR: begin
                    n      = 2'd1;
                    res[0] = mk_res(ITEM_ERROR, 8'd0, TOK_NUMBER, row_o, col_o, FAULT_OPEN);
                end
                MODE_NUMBER, MODE_IDENT, MODE_OPER: begin
                    n      = 2'd1;
                    res[0] = mk_res(ITEM_END, 8'd0, mode_kind(mode_reg), trow_o, tcol_o,
                                    FAULT_NONE);
                end
                default: n = 2'd0;
            endcase
            mode_next   = MODE_NORMAL;
            esc_next    = ESC_NONE;
            digits_next = 3'd0;
            hex_next    = 16'd0;
            row_next    = POSITION_BITS'(1);
            col_next    = '0;
            trow_next   = '0;
            tcol_next   = '0;
        end else begin
            col_next = col_inc;
            unique case (mode_reg)
                MODE_COMMENT: begin
                    if (c == CH_HASH) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_STRING, MODE_CHAR: begin
                    unique case (esc_reg)
                        ESC_SLASH: begin
                            esc_next = ESC_NONE;
                            if (c == CH_LOWER_U || c == CH_LOWER_X) begin
                                esc_next    = ESC_HEX;
                                digits_next = (c == CH_LOWER_U) ? 3'd4 : 3'd2;
                                hex_next    = 16'd0;
                            end else begin
                                n      = 2'd1;
                                res[0] = mk_res(ITEM_TEXT, esc_map(c), mode_kind(mode_reg),
                                                trow_o, tcol_o, FAULT_NONE);
                            end
                        end
                        ESC_HEX: begin
                            if (!hx[4]) begin
                                esc_next    = ESC_NONE;
                                digits_next = 3'd0;
                                hex_next    = 16'd0;
                                n           = 2'd1;
                                res[0]      = mk_res(ITEM_ERROR, 8'd0, TOK_NUMBER, row_o,
                                                     coli_o, FAULT_BAD_HEX);
                            end else begin
                                hex_next    = hex_acc;
                                digits_next = digits_dec;
                                if (digits_dec == 3'd0) begin
                                    esc_next = ESC_NONE;
                                    n        = 2'd1;
                                    res[0]   = mk_res(ITEM_TEXT, hex_acc[7:0],
                                                      mode_kind(mode_reg), trow_o, tcol_o,
                                                      FAULT_NONE);
                                end
                            end
                        end
                        default: begin
                            if (c == ((mode_reg == MODE_CHAR) ? CH_SQUOTE : CH_DQUOTE)) begin
                                mode_next = MODE_NORMAL;
                                n         = 2'd1;
                                res[0]    = mk_res(ITEM_END, 8'd0, mode_kind(mode_reg),
                                                   trow_o, tcol_o, FAULT_NONE);
                            end else if (c == CH_BSLASH) begin
                                esc_next = ESC_SLASH;
                            end else begin
                                n      = 2'd1;
                                res[0] = mk_res(ITEM_TEXT, c, mode_kind(mode_reg),
                                                trow_o, tcol_o, FAULT_NONE);
                            end
                        end
                    endcase
                end
                MODE_NUMBER, MODE_IDENT, MODE_OPER: begin
                    unique case (mode_reg)
                        MODE_NUMBER: more = is_digit(c) || c == CH_DOT;
                        MODE_IDENT:  more = is_alpha(c) || is_digit(c) || c == CH_UNDER;
                        default:     more = is_op(c);
                    endcase
                    if (more) begin
                        n      = 2'd1;
                        res[0] = mk_res(ITEM_TEXT, c, mode_kind(mode_reg), trow_o, tcol_o,
                                        FAULT_NONE);
                    end else begin
                        res[0]    = mk_res(ITEM_END, 8'd0, mode_kind(mode_reg), trow_o,
                                           tcol_o, FAULT_NONE);
                        res[1]    = nb_r0;
                        res[2]    = nb_r1;
                        n         = nb_n + 2'd1;
                        mode_next = nb_mode;
                        if (nb_mark) begin
                            trow_next = row_reg;
                            tcol_next = col_inc;
                        end
                    end
                end
                default: begin
                    res[0]    = nb_r0;
                    res[1]    = nb_r1;
                    n         = nb_n;
                    mode_next = nb_mode;
                    if (nb_mark) begin
                        trow_next = row_reg;
                        tcol_next = col_inc;
                    end
                end
            endcase
            if (c == CH_NEWLINE) begin
                row_next = (row_reg != POS_MAX) ? row_reg + 1'b1 : row_reg;
                col_next = '0;
            end
        end
        res[0].last = (n == 2'd1);
        res[1].last = (n == 2'd2);
        res[2].last = (n == 2'd3);
    end

    // result queue: head at slot 0, shifts down on each output handshake
    assign s_axis_tready = (cnt_reg <= 3'd1);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign base          = cnt_reg - {2'b0, pop};

    always_comb begin
        off = 3'd0;
        for (int i = 0; i < 4; i++) begin
            q_next[i] = (pop && i < 3) ? q_reg[(i < 3) ? i + 1 : i] : q_reg[i];
            off       = 3'(i) - base;
            if (push && 3'(i) >= base && off < {1'b0, n}) begin
                q_next[i] = res[off[1:0]];
            end
        end
        cnt_next = base + (push ? {1'b0, n} : 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            esc_reg    <= ESC_NONE;
            digits_reg <= 3'd0;
            hex_reg    <= 16'd0;
            row_reg    <= POSITION_BITS'(1);
            col_reg    <= '0;
            trow_reg   <= '0;
            tcol_reg   <= '0;
            cnt_reg    <= 3'd0;
        end else begin
            if (push) begin
                mode_reg   <= mode_next;
                esc_reg    <= esc_next;
                digits_reg <= digits_next;
                hex_reg    <= hex_next;
                row_reg    <= row_next;
                col_reg    <= col_next;
                trow_reg   <= trow_next;
                tcol_reg   <= tcol_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = {3'b000, q_reg[0].fault, q_reg[0].col, q_reg[0].row,
                            q_reg[0].tkind, q_reg[0].text};
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tlast  = q_reg[0].last;

endmodule

`default_nettype wire

[hw/rtl/sttok_checker.sv]
// Port-level checks for the source text tokeniser, bound to the top level.
// Depends on sttok_pkg and source_text_tokenizer_unit.
`timescale 1ns / 1ps
`default_nettype none

module sttok_checker
    import sttok_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // queue is empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output word present after reset");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == ITEM_TEXT || m_axis_tuser == ITEM_END ||
                           m_axis_tuser == ITEM_ERROR))
        else $error("bad item kind");

    // error words carry a fault and no text; other words carry no fault
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ITEM_ERROR) |->
            (m_axis_tdata[10:0] == 11'd0 && m_axis_tdata[44:43] != FAULT_NONE &&
             m_axis_tlast))
        else $error("malformed error word");

    a_token_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != ITEM_ERROR) |->
            (m_axis_tdata[44:43] == FAULT_NONE && m_axis_tdata[26:11] != 16'd0))
        else $error("token word with fault or zero row");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output word changed under stall");

endmodule

bind source_text_tokenizer_unit sttok_checker u_sttok_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
